// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
// No dependencies; pulled in with an include by the deframer top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Property must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/slcd_pkg.sv =====
// Shared types and constants of the sync/length/checksum deframer.
// No dependencies.
package slcd_pkg;

    // Configuration register index and codes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_HEADER  = 1'b0;
    localparam cfg_index_t REG_TRAILER = 1'b1;

    // Register reset values
    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [7:0] TRAILER_RESET = 8'h0D;

    // Frame layout: header, length, checksum, trailer around the payload
    localparam logic [8:0] FRAME_OVERHEAD = 9'd4;
    localparam int         MIN_SCAN       = 5;
    localparam int         WORD_BYTES     = 8;

    // Scan sequencer states
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SCAN = 9'b000000010,
        ST_HDR  = 9'b000000100,
        ST_LEN  = 9'b000001000,
        ST_TRL  = 9'b000010000,
        ST_SUM  = 9'b000100000,
        ST_CHK  = 9'b001000000,
        ST_EMIT = 9'b010000000,
        ST_PUSH = 9'b100000000
    } state_t;

endpackage

// ===== rtl/slcd_store.sv =====
// Circular byte store: one write port, one registered read port, both
// addressed as an offset from the oldest byte. No package dependencies.
module slcd_store #(
    parameter int DEPTH = 512,
    parameter int PW    = 9
) (
    input  logic          clk,
    input  logic [PW-1:0] head,
    input  logic          wr_en,
    input  logic [PW-1:0] wr_off,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [PW-1:0] rd_off,
    output logic [7:0]    rd_data
);

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_data_reg;
    logic [PW:0] wr_sum;
    logic [PW:0] rd_sum;
    logic [PW:0] wr_wrap;
    logic [PW:0] rd_wrap;

    // Offset to physical address; the sum stays below twice the depth
    assign wr_sum  = {1'b0, head} + {1'b0, wr_off};
    assign rd_sum  = {1'b0, head} + {1'b0, rd_off};
    assign wr_wrap = (wr_sum >= (PW+1)'(DEPTH)) ? wr_sum - (PW+1)'(DEPTH) : wr_sum;
    assign rd_wrap = (rd_sum >= (PW+1)'(DEPTH)) ? rd_sum - (PW+1)'(DEPTH) : rd_sum;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_wrap[PW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_wrap[PW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sync_length_checksum_deframer.sv =====
// Top of the sync/length/checksum deframer: store, sequencer, config, output regs.
// Depends on slcd_pkg, slcd_store and assert_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_stall    | rx_byte
//  output   | out_valid / out_stall  | frame_word, byte_count, frame_end
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every stored byte is read through the single read port of the store, at most
// one byte per cycle while the output is not stalled. Fewer than five stored
// bytes end the scan; a front byte that starts no frame is dropped alone, an
// incomplete frame waits, a good frame's payload is read for the sum and again
// for the output words. in_stall is high from acceptance until the scan is done.
// Reset clears state, pointers, out_valid and config, not datapath regs or store.
`include "assert_macros.svh"

module sync_length_checksum_deframer #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          frame_word,
    output logic [3:0]           byte_count,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  slcd_pkg::cfg_index_t cfg_index,
    input  logic [7:0]           cfg_data
);

    import slcd_pkg::*;

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    header_reg, trailer_reg;
    logic [7:0]    len_reg, len_next;
    logic [8:0]    frame_len_reg, frame_len_next;
    logic [8:0]    idx_reg, idx_next;
    logic [7:0]    sum_reg, sum_next;
    logic [63:0]   asm_reg, asm_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   frame_word_reg, frame_word_next;
    logic [3:0]    byte_count_reg, byte_count_next;
    logic          frame_end_reg, frame_end_next;

    logic          wr_en;
    logic [PW-1:0] wr_off;
    logic          rd_en;
    logic [PW-1:0] rd_off;
    logic [7:0]    rd_data;
    logic          in_take;
    logic          full;
    logic [8:0]    drop_n;
    logic [8:0]    fl_calc;
    logic [8:0]    last_idx;
    logic [2:0]    lane;
    logic          word_done;
    logic [PW:0]   head_sum;
    logic [PW:0]   head_wrap;

    slcd_store #(
        .DEPTH (BUFFER_DEPTH),
        .PW    (PW)
    ) u_store (
        .clk     (clk),
        .head    (head_reg),
        .wr_en   (wr_en),
        .wr_off  (wr_off),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_off  (rd_off),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign full      = (count_reg == CW'(BUFFER_DEPTH));
    assign fl_calc   = {1'b0, rd_data} + FRAME_OVERHEAD;
    assign last_idx  = frame_len_reg - 9'd1;
    assign lane      = idx_reg[2:0];
    assign word_done = (lane == 3'(WORD_BYTES - 1)) || (idx_reg == last_idx);

    // Head advance by the dropped byte count, wrapped at the store depth
    assign head_sum  = {1'b0, head_reg} + (PW+1)'(drop_n);
    assign head_wrap = (head_sum >= (PW+1)'(BUFFER_DEPTH)) ?
                       head_sum - (PW+1)'(BUFFER_DEPTH) : head_sum;
    assign head_next = head_wrap[PW-1:0];
    assign count_next = count_reg - CW'(drop_n) + CW'(wr_en);

    // Scan sequencer
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        frame_len_next  = frame_len_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        asm_next        = asm_reg;
        frame_word_next = frame_word_reg;
        byte_count_next = byte_count_reg;
        frame_end_next  = frame_end_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_off          = PW'(count_reg);
        rd_en           = 1'b0;
        rd_off          = '0;
        drop_n          = 9'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    wr_en = 1'b1;
                    // store full: overwrite the oldest byte
                    if (full)
                    begin
                        wr_off = '0;
                        drop_n = 9'd1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (count_reg < CW'(MIN_SCAN))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_off     = '0;
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (rd_data != header_reg)
                begin
                    drop_n     = 9'd1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_off     = PW'(1);
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                len_next       = rd_data;
                frame_len_next = fl_calc;
                if (rd_data == 8'd0)
                begin
                    drop_n     = 9'd1;
                    state_next = ST_SCAN;
                end
                else if (count_reg < CW'(fl_calc))
                begin
                    // frame not complete yet
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_off     = PW'(fl_calc - 9'd1);
                    state_next = ST_TRL;
                end
            end
            ST_TRL:
            begin
                if (rd_data != trailer_reg)
                begin
                    drop_n     = 9'd1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    sum_next   = 8'd0;
                    idx_next   = 9'd2;
                    rd_en      = 1'b1;
                    rd_off     = PW'(2);
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // one payload byte per cycle through the adder
                sum_next = sum_reg + rd_data;
                rd_en    = 1'b1;
                if (idx_reg == {1'b0, len_reg} + 9'd1)
                begin
                    rd_off     = PW'({1'b0, len_reg} + 9'd2);
                    state_next = ST_CHK;
                end
                else
                begin
                    idx_next = idx_reg + 9'd1;
                    rd_off   = PW'(idx_reg + 9'd1);
                end
            end
            ST_CHK:
            begin
                if (rd_data != sum_reg)
                begin
                    drop_n     = frame_len_reg;
                    state_next = ST_SCAN;
                end
                else
                begin
                    idx_next   = 9'd0;
                    asm_next   = '0;
                    rd_en      = 1'b1;
                    rd_off     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                asm_next[{lane, 3'b000} +: 8] = rd_data;
                if (word_done)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + 9'd1;
                    rd_en    = 1'b1;
                    rd_off   = PW'(idx_reg + 9'd1);
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    frame_word_next = asm_reg;
                    byte_count_next = 4'(lane) + 4'd1;
                    frame_end_next  = (idx_reg == last_idx);
                    if (idx_reg == last_idx)
                    begin
                        drop_n     = frame_len_reg;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        asm_next   = '0;
                        idx_next   = idx_reg + 9'd1;
                        rd_en      = 1'b1;
                        rd_off     = PW'(idx_reg + 9'd1);
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RESET;
            trailer_reg <= TRAILER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEADER:  header_reg  <= cfg_data;
                REG_TRAILER: trailer_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        frame_len_reg  <= frame_len_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        asm_reg        <= asm_next;
        frame_word_reg <= frame_word_next;
        byte_count_reg <= byte_count_next;
        frame_end_reg  <= frame_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_word = frame_word_reg;
    assign byte_count = byte_count_reg;
    assign frame_end  = frame_end_reg;

    // Checks
    `ASSERT_SAME(a_idle_count, clk, rst_n, state_reg == ST_IDLE, count_reg < CW'(259))
    `ASSERT_SAME(a_emit_idx, clk, rst_n, state_reg == ST_EMIT, idx_reg < frame_len_reg)
    `ASSERT_SAME(a_sum_idx, clk, rst_n, state_reg == ST_SUM, idx_reg <= {1'b0, len_reg} + 9'd1)
    `ASSERT_NEXT(a_push_end, clk, rst_n, state_reg == ST_PUSH && state_next == ST_SCAN, out_valid && frame_end)

endmodule
